/* rtl/tdlm_pkg.sv */
// Shared types, register indexes and helper functions for the tanh drive lowpass mix block.
// Used by tdlm_ctrl, tdlm_datapath and tanh_drive_lowpass_mix_core; no dependencies.
package tdlm_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B0     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A1     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_A2     = 3'd6;

    localparam logic [22:0] DRIVE_MIN = 23'd65536;
    localparam logic [16:0] TRIM_MIN  = 17'd22938;
    localparam logic [16:0] TRIM_MAX  = 17'd65536;
    localparam logic [15:0] MIX_MAX   = 16'd52429;

    typedef struct packed {
        logic               enable;
        logic [22:0]        drive;
        logic [16:0]        trim;
        logic [15:0]        mix;
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DRIVE,
        OP_LOOKUP,
        OP_INTERP,
        OP_TRIM,
        OP_B0,
        OP_A1,
        OP_A2,
        OP_MIX
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
    } dp_stat_t;

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Long division for elaboration-time table construction only.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/depth) in Q.30: exp(-u) by series, squared four times, then (1-e)/(1+e).
    function automatic logic [30:0] tanh_entry(input int unsigned k, input int unsigned depth);
        logic [63:0]        u;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        num;
        logic [63:0]        den;
        logic signed [63:0] acc;
        u    = udiv(64'(k) << 30, 64'(depth));
        term = 64'd1 << 31;
        acc  = signed'(term);
        for (int n = 1; n <= 14; n++) begin
            term = udiv(term * u, 64'(n) << 31);
            if ((n & 1) == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        e = (acc < 0) ? 64'd0 : unsigned'(acc);
        for (int s = 0; s < 4; s++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        if (e > (64'd1 << 31)) begin
            e = 64'd1 << 31;
        end
        num = ((64'd1 << 31) - e) << 30;
        den = (64'd1 << 31) + e;
        return 31'(udiv(num + (den >> 1), den));
    endfunction

endpackage

/* rtl/tdlm_ctrl.sv */
// Sequencer for the tanh drive lowpass mix block: steps the datapath through one item.
// Depends on tdlm_pkg for the command and status types.
module tdlm_ctrl import tdlm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_DRIVE  = 10'b0000000010,
        ST_LOOKUP = 10'b0000000100,
        ST_INTERP = 10'b0000001000,
        ST_TRIM   = 10'b0000010000,
        ST_B0     = 10'b0000100000,
        ST_A1     = 10'b0001000000,
        ST_A2     = 10'b0010000000,
        ST_MIX    = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                cmd.op     = OP_DRIVE;
                state_next = stat.bypass ? ST_DONE : ST_LOOKUP;
            end
            ST_LOOKUP: begin
                cmd.op     = OP_LOOKUP;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.op     = OP_INTERP;
                state_next = ST_TRIM;
            end
            ST_TRIM: begin
                cmd.op     = OP_TRIM;
                state_next = ST_B0;
            end
            ST_B0: begin
                cmd.op     = OP_B0;
                state_next = ST_A1;
            end
            ST_A1: begin
                cmd.op     = OP_A1;
                state_next = ST_A2;
            end
            ST_A2: begin
                cmd.op     = OP_A2;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.op     = OP_MIX;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/tdlm_datapath.sv */
// Datapath of the tanh drive lowpass mix block: shared multiplier, tanh table,
// per-channel biquad state and output register. Depends on tdlm_pkg.
module tdlm_datapath import tdlm_pkg::*; #(
    parameter int NUM_CHANNELS     = 2,
    parameter int TANH_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  cfg_t                          cfg,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_channel,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int MW      = (SAMPLE_BITS + 5 > 33) ? SAMPLE_BITS + 5 : 33;
    localparam int PW      = 2 * MW;
    localparam int P_W     = SAMPLE_BITS + 24;
    localparam int LIM_SH  = SAMPLE_BITS + 17;
    localparam int IDX_W   = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int Q_W     = LIM_SH + IDX_W;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SH      = 29 - SAMPLE_BITS;
    localparam int SH_R    = (SH > 0) ? SH : 1;
    localparam int SH_L    = (SH < 0) ? -SH : 0;

    localparam logic signed [63:0] ONE      = 64'sd1;
    localparam logic signed [63:0] HALF30   = ONE <<< 29;
    localparam logic signed [63:0] HALF16   = ONE <<< 15;
    localparam logic signed [63:0] HALF_WET = ONE <<< (SH_R - 1);
    localparam logic signed [63:0] Y_MAX    = (ONE <<< 31) - ONE;
    localparam logic signed [63:0] ST_MAX   = (ONE <<< 39) - ONE;
    localparam logic signed [63:0] S_MAX    = (ONE <<< (SAMPLE_BITS - 1)) - ONE;

    typedef logic [30:0] rom_t [TANH_TABLE_DEPTH+1];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
            r[k] = tanh_entry(k, TANH_TABLE_DEPTH);
        end
        return r;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    logic signed [SAMPLE_BITS-1:0] dry_reg;
    logic                          ch_reg;
    logic signed [P_W-1:0]         p_reg;
    logic                          neg_reg;
    logic                          sat_reg;
    logic [15:0]                   f_reg;
    logic [30:0]                   lo_reg;
    logic [30:0]                   hi_reg;
    logic [30:0]                   clip_reg;
    logic signed [29:0]            v_reg;
    logic signed [61:0]            pb_reg;
    logic signed [31:0]            y_reg;
    logic signed [MW-1:0]          wet_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic signed [39:0]            st0_reg [NUM_CHANNELS];
    logic signed [39:0]            st1_reg [NUM_CHANNELS];

    logic [22:0]          gain;
    logic [16:0]          trim;
    logic [15:0]          mix;
    logic [CH_W-1:0]      ch_idx;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [63:0]   prod64;
    logic signed [63:0]   p64;
    logic [63:0]          a_abs;
    logic                 sat;
    logic [Q_W-1:0]       q;
    logic [IDX_W-1:0]     idx;
    logic signed [63:0]   mag64;
    logic signed [63:0]   w64;
    logic signed [63:0]   pb64;
    logic signed [63:0]   t_b;
    logic signed [63:0]   t_2b;
    logic signed [63:0]   t_fb;
    logic signed [63:0]   y_sum;
    logic signed [63:0]   s0_sum;
    logic signed [63:0]   s1_sum;
    logic signed [63:0]   y64;
    logic signed [63:0]   wet64;
    logic signed [63:0]   res_sum;
    logic signed [63:0]   st0_cur;
    logic signed [63:0]   st1_cur;

    assign gain   = (cfg.drive < DRIVE_MIN) ? DRIVE_MIN : cfg.drive;
    assign trim   = (cfg.trim < TRIM_MIN) ? TRIM_MIN : ((cfg.trim > TRIM_MAX) ? TRIM_MAX : cfg.trim);
    assign mix    = (cfg.mix > MIX_MAX) ? MIX_MAX : cfg.mix;
    assign ch_idx = CH_W'(ch_reg);

    assign stat.bypass = !cfg.enable || (32'(ch_reg) >= NUM_CHANNELS);
    assign out_sample  = out_reg;

    // One shared multiplier; the operands depend on the step in progress.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_DRIVE: begin
                mul_a = MW'(dry_reg);
                mul_b = MW'({1'b0, gain});
            end
            OP_INTERP: begin
                mul_a = MW'({1'b0, hi_reg - lo_reg});
                mul_b = MW'({1'b0, f_reg});
            end
            OP_TRIM: begin
                mul_a = MW'({1'b0, clip_reg});
                mul_b = MW'({1'b0, trim});
            end
            OP_B0: begin
                mul_a = MW'(cfg.b0);
                mul_b = MW'(v_reg);
            end
            OP_A1: begin
                mul_a = MW'(cfg.a1);
                mul_b = MW'(y_reg);
            end
            OP_A2: begin
                mul_a = MW'(cfg.a2);
                mul_b = MW'(y_reg);
            end
            OP_MIX: begin
                mul_a = wet_reg - MW'(dry_reg);
                mul_b = MW'({1'b0, mix});
            end
            default: begin
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod64 = prod[63:0];

    always_comb begin
        p64   = 64'(p_reg);
        a_abs = (p_reg < 0) ? unsigned'(-p64) : unsigned'(p64);
        sat   = a_abs >= (64'd1 << LIM_SH);
        q     = Q_W'(a_abs[LIM_SH-1:0]) * Q_W'(TANH_TABLE_DEPTH);
        idx   = sat ? '0 : q[Q_W-1:LIM_SH];

        mag64 = {33'b0, 31'((prod64 + HALF16) >>> 16)};
        w64   = neg_reg ? -mag64 : mag64;

        st0_cur = 64'(st0_reg[ch_idx]);
        st1_cur = 64'(st1_reg[ch_idx]);
        pb64    = 64'(pb_reg);
        t_b     = (pb64 + HALF30) >>> 30;
        t_2b    = ((pb64 <<< 1) + HALF30) >>> 30;
        t_fb    = (prod64 + HALF30) >>> 30;
        y_sum   = ((prod64 + HALF30) >>> 30) + st0_cur;
        s0_sum  = t_2b - t_fb + st1_cur;
        s1_sum  = t_b - t_fb;

        y64 = 64'(y_reg);
        if (SH > 0) begin
            wet64 = (y64 + HALF_WET) >>> SH_R;
        end else begin
            wet64 = y64 <<< SH_L;
        end
        res_sum = 64'(dry_reg) + ((prod64 + HALF16) >>> 16);
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                dry_reg <= in_sample;
                ch_reg  <= in_channel;
            end
            OP_DRIVE: begin
                p_reg <= P_W'(prod);
            end
            OP_LOOKUP: begin
                neg_reg <= p_reg < 0;
                sat_reg <= sat;
                f_reg   <= q[LIM_SH-1:LIM_SH-16];
                lo_reg  <= TANH_ROM[idx];
                hi_reg  <= TANH_ROM[idx + 1'b1];
            end
            OP_INTERP: begin
                clip_reg <= sat_reg ? (31'd1 << 30)
                                    : lo_reg + 31'((prod64 + HALF16) >>> 16);
            end
            OP_TRIM: begin
                v_reg <= 30'((w64 + 64'sd2) >>> 2);
            end
            OP_B0: begin
                pb_reg <= prod[61:0];
                y_reg  <= 32'(clamp64(y_sum, -Y_MAX - ONE, Y_MAX));
            end
            OP_A2: begin
                wet_reg <= MW'(wet64);
            end
            OP_MIX: begin
                res_reg <= SAMPLE_BITS'(clamp64(res_sum, -S_MAX - ONE, S_MAX));
            end
            default: begin
            end
        endcase
        if (cmd.load_out) begin
            out_reg <= stat.bypass ? dry_reg : res_reg;
        end
    end

    // Filter delay terms: the first is updated after y is known, the second one step later.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                st0_reg[c] <= '0;
                st1_reg[c] <= '0;
            end
        end else if (cmd.op == OP_A1) begin
            st0_reg[ch_idx] <= 40'(clamp64(s0_sum, -ST_MAX - ONE, ST_MAX));
        end else if (cmd.op == OP_A2) begin
            st1_reg[ch_idx] <= 40'(clamp64(s1_sum, -ST_MAX - ONE, ST_MAX));
        end
    end

endmodule

/* rtl/tanh_drive_lowpass_mix_core.sv */
// Top level of the tanh drive lowpass mix block: configuration registers, sequencer
// and datapath. Depends on tdlm_pkg, tdlm_ctrl and tdlm_datapath.
//
//   channel   direction  ports                          contents
//   s_        in         s_tvalid/s_tready/s_tdata/s_tuser  one sample and its channel
//   m_        out        m_tvalid/m_tready/m_tdata          one processed sample
//   cfg_      in         cfg_wr_en/cfg_index/cfg_wr_data    register writes
//
// A processed sample passes the drive, lookup, interpolation, trim, filter, mix and done
// steps to the output register; the next transfer in is taken in the idle state.
// One multiplier is shared over the drive, interpolation, trim, three filter and mix
// products. A bypassed sample (disabled or channel without state) skips from the drive
// to the done step. Reset clears control and filter state and loads the configuration
// defaults. A result waiting in the output register does not block the next transfer
// in; a second finished result waits in its last step until the output register is free.
module tanh_drive_lowpass_mix_core import tdlm_pkg::*; #(
    parameter int NUM_CHANNELS     = 2,
    parameter int TANH_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample_in
    input  logic                                   s_tuser,   // channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // sample_out
    input  logic                                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [31:0]                            cfg_wr_data
);

    localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.drive  <= DRIVE_MIN;
            cfg_reg.trim   <= TRIM_MAX;
            cfg_reg.mix    <= '0;
            cfg_reg.b0     <= '0;
            cfg_reg.a1     <= '0;
            cfg_reg.a2     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE: cfg_reg.enable <= cfg_wr_data[0];
                CFG_DRIVE:  cfg_reg.drive  <= cfg_wr_data[22:0];
                CFG_TRIM:   cfg_reg.trim   <= cfg_wr_data[16:0];
                CFG_MIX:    cfg_reg.mix    <= cfg_wr_data[15:0];
                CFG_B0:     cfg_reg.b0     <= signed'(cfg_wr_data);
                CFG_A1:     cfg_reg.a1     <= signed'(cfg_wr_data);
                CFG_A2:     cfg_reg.a2     <= signed'(cfg_wr_data);
                default: begin
                end
            endcase
        end
    end

    tdlm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tdlm_datapath #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg_reg),
        .in_sample  (signed'(s_tdata[SAMPLE_BITS-1:0])),
        .in_channel (s_tuser),
        .out_sample (out_sample)
    );

    assign m_tdata = TD_W'(unsigned'(out_sample));

    // The sequencer takes one item at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A result only appears as the sequencer returns to idle.
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");

    // With processing off and no result waiting, the sample comes out unchanged.
    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !cfg_reg.enable && !m_tvalid) |->
        ##3 (m_tvalid && m_tdata[SAMPLE_BITS-1:0] == $past(s_tdata[SAMPLE_BITS-1:0], 3)))
        else $error("bypassed sample changed or late");

endmodule

/* bench/tb_tanh_drive_lowpass_mix_core.sv */
// Self-checking bench for tanh_drive_lowpass_mix_core: random and directed samples are
// streamed in and every output is compared with a bit-exact software predictor.
// Depends on tdlm_pkg and the RTL of the block.
`timescale 1ns / 1ps

class distortion_scoreboard;
    longint      tanh_q30[0:256];
    bit          en;
    bit [22:0]   drive;
    bit [16:0]   trim;
    bit [15:0]   mix;
    longint      b0, a1, a2;
    longint      delay[0:1][0:1];
    bit [23:0]   expected_samples[$];
    int          errors;
    int          checked;
    int          wet_count;

    function new();
        longint unsigned u, term, e, num, den;
        longint          acc;
        for (int k = 0; k <= 256; k++) begin
            u    = (longint'(k) << 30) / 256;
            term = 64'd1 << 31;
            acc  = longint'(term);
            for (int n = 1; n <= 14; n++) begin
                term = (term * u) / (longint'(n) << 31);
                if (n % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            e = (acc < 0) ? 0 : acc;
            for (int s = 0; s < 4; s++) e = (e * e + (64'd1 << 30)) >> 31;
            if (e > (64'd1 << 31)) e = 64'd1 << 31;
            num = ((64'd1 << 31) - e) << 30;
            den = (64'd1 << 31) + e;
            tanh_q30[k] = longint'((num + den / 2) / den);
        end
        clear_state();
    endfunction

    function void clear_state();
        en = 0; drive = 65536; trim = 65536; mix = 0;
        b0 = 0; a1 = 0; a2 = 0;
        for (int c = 0; c < 2; c++) begin
            delay[c][0] = 0;
            delay[c][1] = 0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            tdlm_pkg::CFG_ENABLE: en = val[0];
            tdlm_pkg::CFG_DRIVE:  drive = val[22:0];
            tdlm_pkg::CFG_TRIM:   trim = val[16:0];
            tdlm_pkg::CFG_MIX:    mix = val[15:0];
            tdlm_pkg::CFG_B0:     b0 = longint'(signed'(val));
            tdlm_pkg::CFG_A1:     a1 = longint'(signed'(val));
            tdlm_pkg::CFG_A2:     a2 = longint'(signed'(val));
            default: ;
        endcase
    endfunction

    static function longint round_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    static function longint sat(longint x, longint lim);
        return (x < -lim - 1) ? -lim - 1 : ((x > lim) ? lim : x);
    endfunction

    // Drive, soft clip, trim, lowpass and dry/wet mix for one sample, or the raw sample when disabled.
    function bit [23:0] process_sample(bit [23:0] raw, bit ch);
        longint dry, g, tr, m, p, a, q, idx, f, clip, mag, w, v, y, n0, n1, wet, res;
        dry = longint'(signed'(raw));
        if (!en) return raw;
        wet_count++;
        g  = (drive < 65536) ? 65536 : drive;
        tr = (trim < 22938) ? 22938 : ((trim > 65536) ? 65536 : trim);
        m  = (mix > 52429) ? 52429 : mix;
        p  = dry * g;
        a  = (p < 0) ? -p : p;
        if (a >= (longint'(1) << 41)) begin
            clip = longint'(1) << 30;
        end else begin
            q    = a * 256;
            idx  = q >> 41;
            f    = (q & ((longint'(1) << 41) - 1)) >> 25;
            clip = tanh_q30[idx] + (((tanh_q30[idx+1] - tanh_q30[idx]) * f + 32768) >> 16);
        end
        mag = (clip * tr + 32768) >> 16;
        w   = (p < 0) ? -mag : mag;
        v   = round_shift(w, 2);
        y   = sat(round_shift(b0 * v, 30) + delay[ch][0], 64'sd2147483647);
        n0  = sat(round_shift(2 * b0 * v, 30) - round_shift(a1 * y, 30) + delay[ch][1],
                  64'sd549755813887);
        n1  = sat(round_shift(b0 * v, 30) - round_shift(a2 * y, 30), 64'sd549755813887);
        delay[ch][0] = n0;
        delay[ch][1] = n1;
        wet = round_shift(y, 5);
        res = sat(dry + round_shift((wet - dry) * m, 16), 64'sd8388607);
        return res[23:0];
    endfunction

    function void note_input(bit [23:0] raw, bit ch);
        expected_samples.push_back(process_sample(raw, ch));
    endfunction

    function void check_result(bit [23:0] got);
        bit [23:0] exp_val;
        checked++;
        if (expected_samples.size() == 0) begin
            $error("sample_out: unexpected transfer, actual %0d", $signed(got));
            errors++;
            return;
        end
        exp_val = expected_samples.pop_front();
        if (got !== exp_val) begin
            $error("sample_out: expected %0d, actual %0d", $signed(exp_val), $signed(got));
            errors++;
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb_tanh_drive_lowpass_mix_core;
    import tdlm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wr_data = '0;

    distortion_scoreboard sb = new();
    bit  idle_on = 1;
    bit  hold_req = 0;
    int  cycles = 0;
    int  sent = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    tanh_drive_lowpass_mix_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // Both channels are observed at the edge, before any driver update lands.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tanh_drive_lowpass_mix_core test failed");
            $finish;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    always begin
        if (hold_req) begin
            m_tready <= 0;
            repeat (300) @(posedge aclk);
            hold_req = 0;
        end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
            m_tready <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end else begin
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en   <= 1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [23:0] x, logic ch);
        s_tvalid <= 1;
        s_tdata  <= x;
        s_tuser  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 4000)) - 2000);
            2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    // Mostly stable lowpass settings, sometimes fully random coefficients.
    task automatic random_config();
        int pick;
        pick = $urandom_range(0, 3);
        write_reg(CFG_ENABLE, 32'($urandom_range(0, 5) != 0));
        write_reg(CFG_DRIVE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(65536, 8388607));
        write_reg(CFG_TRIM, $urandom_range(0, 131071));
        write_reg(CFG_MIX, $urandom_range(0, 65535));
        if (pick == 0) begin
            write_reg(CFG_B0, $urandom);
            write_reg(CFG_A1, $urandom);
            write_reg(CFG_A2, $urandom);
        end else begin
            write_reg(CFG_B0, $urandom_range(1000, 60000000));
            write_reg(CFG_A1, -$urandom_range(800000000, 2000000000));
            write_reg(CFG_A2, $urandom_range(200000000, 900000000));
        end
        end_writes();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Pass-through with extremes, then the same extremes through the effect.
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_ENABLE, 0);
        end_writes();
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h000000, 1'b0);
        drain();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_DRIVE, 8388607);
        write_reg(CFG_TRIM, 22938);
        write_reg(CFG_MIX, 52429);
        write_reg(CFG_B0, 32'h7FFF_FFFF);
        write_reg(CFG_A1, 32'h8000_0000);
        write_reg(CFG_A2, 32'h7FFF_FFFF);
        end_writes();
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h000001, 1'b1);
        send_sample(24'hFFFFFF, 1'b0);
        drain();
        // Out-of-range register values are held to their limits.
        write_reg(CFG_DRIVE, 0);
        write_reg(CFG_TRIM, 131071);
        write_reg(CFG_MIX, 65535);
        write_reg(CFG_B0, 32'h0100_0000);
        write_reg(CFG_A1, 32'hC000_0000);
        write_reg(CFG_A2, 32'h1000_0000);
        end_writes();
        send_sample(24'h400000, 1'b0);
        send_sample(24'hC00000, 1'b1);
        send_sample(24'h123456, 1'b0);
        drain();
        write_reg(CFG_DRIVE, 65536);
        write_reg(CFG_TRIM, 0);
        write_reg(CFG_MIX, 0);
        end_writes();
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            if (phase == 7) idle_on = 0;
            for (int i = 0; i < 105; i++) begin
                if (phase == 2 && i == 10) hold_req = 1;
                if (phase == 3 && i == 50) begin
                    s_tvalid <= 0;
                    @(posedge aclk);
                    while (sb.pending() != 0) @(posedge aclk);
                end
                send_sample(rand_sample(), 1'($urandom_range(0, 1)));
            end
            drain();
        end

        repeat (30) @(posedge aclk);
        $display("Covered %0d samples (%0d through the effect path) across 12 settings,",
                 sent, sb.wet_count);
        $display("with back-pressure, a long output stall and a full drain pause.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tanh_drive_lowpass_mix_core test passed");
        end else begin
            $display("tanh_drive_lowpass_mix_core test failed");
        end
        $finish;
    end
endmodule
